@@ hdl/crlw_pkg.sv @@
// Shared types, constants and helper function of the command rate limiter watchdog.
package crlw_pkg;

    // Field widths fixed by the interface.
    localparam int LEVEL_W   = 13;
    localparam int ID_W      = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Default width of the elapsed tick counter.
    localparam int TIMER_BITS_DEF = 24;

    // Millivolt levels.
    localparam logic [LEVEL_W-1:0] FULL_SCALE_MV = 13'd5000;
    localparam logic [LEVEL_W-1:0] STOP_LEVEL_MV = 13'd2500;

    // Register reset values.
    localparam logic [CFG_W-1:0] LONG_TIMEOUT_RST  = 24'd5000;
    localparam logic [CFG_W-1:0] SHORT_TIMEOUT_RST = 24'd1100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIMEOUT = 2'd1;

    // Input operation codes.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_PACKET = 1'b1;

    // Kind of output sent to the actuator.
    typedef enum logic [1:0] {
        KIND_STOP      = 2'd0,
        KIND_IMMEDIATE = 2'd1,
        KIND_FLUSH     = 2'd2
    } t_send_kind;

    // One input item.
    typedef struct packed {
        logic               operation;
        logic [ID_W-1:0]    packet_id;
        logic [LEVEL_W-1:0] lever_one_mv;
        logic [LEVEL_W-1:0] lever_two_mv;
    } t_item;

    // One result item.
    typedef struct packed {
        t_send_kind         send_kind;
        logic [LEVEL_W-1:0] level_a_mv;
        logic [LEVEL_W-1:0] level_b_mv;
        logic [LEVEL_W-1:0] level_c_mv;
        logic [LEVEL_W-1:0] level_d_mv;
    } t_result;

    // Limit a lever level to full scale.
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        return (v > FULL_SCALE_MV) ? FULL_SCALE_MV : v;
    endfunction

endpackage

@@ hdl/crlw_cfg_regs.sv @@
// Timeout configuration registers written through the configuration channel.
module crlw_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [crlw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [crlw_pkg::CFG_W-1:0]     i_cfg_data,
    output logic [crlw_pkg::CFG_W-1:0]     o_long_ticks,
    output logic [crlw_pkg::CFG_W-1:0]     o_short_ticks
);
    import crlw_pkg::*;

    logic [CFG_W-1:0] r_long_ticks;
    logic [CFG_W-1:0] r_short_ticks;

    // Writes are always taken; an unknown index is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks  <= LONG_TIMEOUT_RST;
            r_short_ticks <= SHORT_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LONG_TIMEOUT:  r_long_ticks  <= i_cfg_data;
                CFG_SHORT_TIMEOUT: r_short_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_long_ticks  = r_long_ticks;
    assign o_short_ticks = r_short_ticks;

endmodule

@@ hdl/crlw_in_reg.sv @@
// Input register that holds one accepted item until the core takes it.
module crlw_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  crlw_pkg::t_item i_item,
    output logic            o_valid,
    output crlw_pkg::t_item o_item,
    input  logic            i_consume
);
    import crlw_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // The slot frees up in the same cycle the core takes its item.
    assign o_ready = !r_valid || i_consume;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hdl/crlw_core.sv @@
// Rate limiter state and the send decision for one item per cycle while the output has room.
module crlw_core #(
    parameter int TIMER_BITS = crlw_pkg::TIMER_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    input  crlw_pkg::t_item            i_item,
    input  logic                       i_out_free,
    input  logic [crlw_pkg::CFG_W-1:0] i_long_ticks,
    input  logic [crlw_pkg::CFG_W-1:0] i_short_ticks,
    output logic                       o_advance,
    output logic                       o_res_valid,
    output crlw_pkg::t_result          o_res
);
    import crlw_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed, tick_elapsed;
    logic                  r_buffer_full, n_buffer_full;
    logic [LEVEL_W-1:0]    r_held_one, r_held_two;
    logic [ID_W-1:0]       r_newest_id, n_newest_id;
    logic                  r_newest_id_valid, n_newest_id_valid;
    logic                  load_held;

    logic [LEVEL_W-1:0]    lever_one, lever_two;
    logic [CMP_W-1:0]      elapsed_cmp, tick_cmp, long_cmp, short_cmp;
    logic                  id_newer;
    logic                  advance;
    logic                  res_valid;
    t_result               res;

    assign advance = i_item_valid && i_out_free;

    // Clamped levers, saturating tick count and widened compare operands.
    always_comb begin
        lever_one    = clamp_level(i_item.lever_one_mv);
        lever_two    = clamp_level(i_item.lever_two_mv);
        tick_elapsed = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
        elapsed_cmp  = CMP_W'(r_elapsed);
        tick_cmp     = CMP_W'(tick_elapsed);
        long_cmp     = CMP_W'(i_long_ticks);
        short_cmp    = CMP_W'(i_short_ticks);
        id_newer     = !r_newest_id_valid || (i_item.packet_id > r_newest_id);
    end

    // Send decision and next state.
    always_comb begin
        n_elapsed         = r_elapsed;
        n_buffer_full     = r_buffer_full;
        n_newest_id       = r_newest_id;
        n_newest_id_valid = r_newest_id_valid;
        load_held         = 1'b0;
        res_valid         = 1'b0;
        res.send_kind     = KIND_STOP;
        res.level_a_mv    = STOP_LEVEL_MV;
        res.level_b_mv    = STOP_LEVEL_MV;
        res.level_c_mv    = STOP_LEVEL_MV;
        res.level_d_mv    = STOP_LEVEL_MV;

        if (i_item.operation == OP_TICK) begin
            n_elapsed = tick_elapsed;
            if (r_buffer_full) begin
                // Flush the buffered command once the short interval is reached.
                if (tick_cmp >= short_cmp) begin
                    res_valid      = 1'b1;
                    res.send_kind  = KIND_FLUSH;
                    res.level_a_mv = r_held_one;
                    res.level_b_mv = FULL_SCALE_MV - r_held_one;
                    res.level_c_mv = r_held_two;
                    res.level_d_mv = FULL_SCALE_MV - r_held_two;
                    n_buffer_full  = 1'b0;
                    n_elapsed      = '0;
                end
            end else if (tick_cmp >= long_cmp) begin
                // Watchdog: stop output after the long interval of silence.
                res_valid = 1'b1;
                n_elapsed = '0;
            end
        end else begin
            if (!r_buffer_full && (elapsed_cmp > short_cmp)) begin
                // Send the command right away.
                res_valid         = 1'b1;
                res.send_kind     = KIND_IMMEDIATE;
                res.level_a_mv    = lever_one;
                res.level_b_mv    = FULL_SCALE_MV - lever_one;
                res.level_c_mv    = lever_two;
                res.level_d_mv    = FULL_SCALE_MV - lever_two;
                n_elapsed         = '0;
                n_newest_id       = i_item.packet_id;
                n_newest_id_valid = 1'b1;
            end else if (id_newer) begin
                // Newest command wins the buffer; older ones are dropped.
                load_held         = 1'b1;
                n_buffer_full     = 1'b1;
                n_newest_id       = i_item.packet_id;
                n_newest_id_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed         <= '0;
            r_buffer_full     <= 1'b0;
            r_newest_id       <= '0;
            r_newest_id_valid <= 1'b0;
        end else if (advance) begin
            r_elapsed         <= n_elapsed;
            r_buffer_full     <= n_buffer_full;
            r_newest_id       <= n_newest_id;
            r_newest_id_valid <= n_newest_id_valid;
        end
    end

    // Buffered levers are read only while the buffer is full.
    always_ff @(posedge i_clk) begin
        if (advance && load_held) begin
            r_held_one <= lever_one;
            r_held_two <= lever_two;
        end
    end

    assign o_advance   = advance;
    assign o_res_valid = res_valid;
    assign o_res       = res;

`ifndef SYNTHESIS
    // Every send restarts the interval timer.
    a_send_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && res_valid |=> r_elapsed == '0)
        else $error("timer not cleared after a send");

    // A flush only comes out of a full buffer and leaves it empty.
    a_flush_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && res_valid && res.send_kind == KIND_FLUSH |-> r_buffer_full)
        else $error("flush from an empty buffer");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && res_valid && res.send_kind == KIND_FLUSH |=> !r_buffer_full)
        else $error("buffer still full after a flush");

    // A buffered command always has an accepted ID behind it.
    a_full_has_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buffer_full |-> r_newest_id_valid)
        else $error("buffer full without a valid ID");
`endif

endmodule

@@ hdl/crlw_out_reg.sv @@
// Result register that holds one result item until the consumer takes it.
module crlw_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  crlw_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output crlw_pkg::t_result o_res
);
    import crlw_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Room for a new result when empty or being drained this cycle.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ hdl/command_rate_limiter_watchdog_top.sv @@
// Top level of the command rate limiter with stop watchdog.
// Flow: input register holds the item, core decides, output register holds the result.
// Throughput: one item per cycle while the output has room; one state pass per item.
// Items that cause no result still pass through the core.
// A stalled output register holds the core and then the input register.
// Synchronous active-low reset empties both registers, clears the timer, buffer and ID.
module command_rate_limiter_watchdog_top #(
    parameter int TIMER_BITS = crlw_pkg::TIMER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [crlw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [crlw_pkg::CFG_W-1:0]     i_cfg_data,
    // Input item channel.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_operation,
    input  logic [crlw_pkg::ID_W-1:0]      i_packet_id,
    input  logic [crlw_pkg::LEVEL_W-1:0]   i_lever_one_mv,
    input  logic [crlw_pkg::LEVEL_W-1:0]   i_lever_two_mv,
    // Result item channel.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_send_kind,
    output logic [crlw_pkg::LEVEL_W-1:0]   o_level_a_mv,
    output logic [crlw_pkg::LEVEL_W-1:0]   o_level_b_mv,
    output logic [crlw_pkg::LEVEL_W-1:0]   o_level_c_mv,
    output logic [crlw_pkg::LEVEL_W-1:0]   o_level_d_mv
);
    import crlw_pkg::*;

    logic             [CFG_W-1:0] long_ticks, short_ticks;
    t_item            in_item, held_item;
    logic             held_valid;
    logic             advance;
    logic             out_free;
    logic             res_valid;
    t_result          res, out_res;

    assign in_item.operation    = i_operation;
    assign in_item.packet_id    = i_packet_id;
    assign in_item.lever_one_mv = i_lever_one_mv;
    assign in_item.lever_two_mv = i_lever_two_mv;

    crlw_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_long_ticks  (long_ticks),
        .o_short_ticks (short_ticks)
    );

    crlw_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .o_valid   (held_valid),
        .o_item    (held_item),
        .i_consume (advance)
    );

    crlw_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (held_valid),
        .i_item        (held_item),
        .i_out_free    (out_free),
        .i_long_ticks  (long_ticks),
        .i_short_ticks (short_ticks),
        .o_advance     (advance),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    crlw_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_send_kind  = out_res.send_kind;
    assign o_level_a_mv = out_res.level_a_mv;
    assign o_level_b_mv = out_res.level_b_mv;
    assign o_level_c_mv = out_res.level_c_mv;
    assign o_level_d_mv = out_res.level_d_mv;

endmodule
